// ===== sv/ltsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsa_pkg
// Shared sizes, operation codes and cell interface types of the LRU slot
// allocator.
// ----------------------------------------------------------------------------
package ltsa_pkg;

  localparam int SLOTS      = 32;
  localparam int OWNER_BITS = 16;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int RANK_W = SLOT_W;
  localparam int POOL_W = $clog2(SLOTS + 1);
  localparam int CNT_W  = $clog2(SLOTS);

  localparam logic [1:0] KIND_TOUCH = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_PROMOTE,
    CELL_CLAIM,
    CELL_FREE
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [SLOT_W-1:0]     target;
    logic [RANK_W-1:0]     old_rank;
    logic [OWNER_BITS-1:0] owner;
  } cell_cmd_t;

  typedef struct packed {
    logic              found;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] idx;
  } carry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC,
    ST_OUT
  } state_t;

endpackage

// ===== sv/lru_texture_slot_allocator_unit.sv =====
`timescale 1ns / 1ps
// Order: allocate gives its result once the search wave has crossed the cell
//   chain (one cell per cycle) and ST_EXEC and ST_OUT follow; touch, release
//   and unused kinds go straight from acceptance to ST_EXEC and then ST_OUT.
// Throughput: one request in flight; the next is taken the cycle after the
//   result is accepted.
// Reset: slot i has rank i, no slot owned, pool size register = 32, no result held.
// ----------------------------------------------------------------------------
// lru_texture_slot_allocator_unit
// LRU pool of cache slots with owner tags: touch, allocate and release
// requests, one result per request.
// ----------------------------------------------------------------------------
module lru_texture_slot_allocator_unit import ltsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  slots_in_use,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [4:0]  slot,
  input  logic [15:0] owner_id,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  slot_out,
  output logic        evicted_valid,
  output logic [15:0] evicted_owner,
  output logic        status
);

  // Pool size register and its clamped value (0 acts as 1, above SLOTS as SLOTS).
  logic [5:0]        pool_cfg;
  logic [POOL_W-1:0] pool_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_cfg <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      pool_cfg <= slots_in_use;
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    if (pool_cfg == 6'd0) begin
      pool_n = POOL_W'(1);
    end else if (32'(pool_cfg) > SLOTS) begin
      pool_n = POOL_W'(SLOTS);
    end else begin
      pool_n = POOL_W'(pool_cfg);
    end
  end

  // Held request.
  logic [1:0]            req_kind;
  logic [SLOT_W-1:0]     req_slot;
  logic [OWNER_BITS-1:0] req_owner;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_kind  <= kind;
      req_slot  <= SLOT_W'(slot);
      req_owner <= OWNER_BITS'(owner_id);
    end
  end

  // Cell row. The search carry enters cell 0 empty and leaves the last cell
  // holding the in-range slot with the highest rank.
  cell_cmd_t             cmd;
  carry_t                carry [SLOTS+1];
  logic [RANK_W-1:0]     rank_vec  [SLOTS];
  logic                  owned_vec [SLOTS];
  logic [OWNER_BITS-1:0] tag_vec   [SLOTS];

  assign carry[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ltsa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (SLOT_W'(i)),
      .pool_n    (pool_n),
      .cmd       (cmd),
      .carry_in  (carry[i]),
      .carry_out (carry[i+1]),
      .rank      (rank_vec[i]),
      .owned     (owned_vec[i]),
      .tag       (tag_vec[i])
    );
  end

  // Sequencer.
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;

  logic [SLOT_W-1:0] pick;
  logic [SLOT_W-1:0] sel;
  logic              slot_in_range;
  logic              res_load;
  logic [4:0]        res_slot;
  logic              res_ev;
  logic [15:0]       res_owner;
  logic              res_status;

  assign pick          = carry[SLOTS].idx;
  assign sel           = (req_kind == KIND_ALLOC) ? pick : req_slot;
  assign slot_in_range = POOL_W'(req_slot) < pool_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    res_load     = 1'b0;
    res_slot     = 5'(req_slot);
    res_ev       = 1'b0;
    res_owner    = '0;
    res_status   = 1'b0;
    cmd.op       = CELL_NOP;
    cmd.target   = sel;
    cmd.old_rank = rank_vec[sel];
    cmd.owner    = req_owner;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        if (in_valid) begin
          // allocate waits for the search wave to cross every cell
          state_next = (kind == KIND_ALLOC) ? ST_SEARCH : ST_EXEC;
        end
      end
      ST_SEARCH: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(SLOTS - 1)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_load   = 1'b1;
        state_next = ST_OUT;
        case (req_kind)
          KIND_TOUCH: begin
            if (slot_in_range) begin
              cmd.op = CELL_PROMOTE;
            end else begin
              res_status = 1'b1;
            end
          end
          KIND_ALLOC: begin
            cmd.op       = CELL_CLAIM;
            cmd.old_rank = carry[SLOTS].rank;
            res_slot     = 5'(pick);
            res_ev       = owned_vec[pick];
            res_owner    = owned_vec[pick] ? 16'(tag_vec[pick]) : 16'd0;
          end
          KIND_FREE: begin
            if (slot_in_range && owned_vec[req_slot]) begin
              cmd.op    = CELL_FREE;
              res_ev    = 1'b1;
              res_owner = 16'(tag_vec[req_slot]);
            end
          end
          default: begin
            // unused kind: echo the slot, change nothing
          end
        endcase
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (res_load) begin
      slot_out      <= res_slot;
      evicted_valid <= res_ev;
      evicted_owner <= res_owner;
      status        <= res_status;
    end
  end

endmodule

// ===== sv/ltsa_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltsa_cell
// One slot: recency rank, owner tag and valid bit, plus one registered stage
// of the oldest-slot search chain.
// ----------------------------------------------------------------------------
module ltsa_cell import ltsa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SLOT_W-1:0]     cell_idx,
  input  logic [POOL_W-1:0]     pool_n,
  input  cell_cmd_t             cmd,
  input  carry_t                carry_in,
  output carry_t                carry_out,
  output logic [RANK_W-1:0]     rank,
  output logic                  owned,
  output logic [OWNER_BITS-1:0] tag
);

  logic   in_range;
  logic   hit;
  logic   promote;
  carry_t carry_next;

  assign in_range = POOL_W'(cell_idx) < pool_n;
  assign hit      = cmd.target == cell_idx;
  assign promote  = (cmd.op == CELL_PROMOTE) || (cmd.op == CELL_CLAIM);

  // Keep the older of the incoming candidate and this slot.
  always_comb begin
    carry_next = carry_in;
    if (in_range && (!carry_in.found || rank > carry_in.rank)) begin
      carry_next.found = 1'b1;
      carry_next.rank  = rank;
      carry_next.idx   = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
      rank      <= RANK_W'(cell_idx);
      owned     <= 1'b0;
    end else begin
      carry_out <= carry_next;
      if (promote) begin
        if (hit) begin
          rank <= '0;
        end else if (rank < cmd.old_rank) begin
          rank <= rank + RANK_W'(1);
        end
      end
      if (hit && cmd.op == CELL_CLAIM) begin
        owned <= 1'b1;
      end else if (hit && cmd.op == CELL_FREE) begin
        owned <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && cmd.op == CELL_CLAIM) begin
      tag <= cmd.owner;
    end
  end

endmodule
